### rtl/sfh_pkg.sv
// Package with shared types, constants and mixing functions of the SuperFastHash byte stream.
package sfh_pkg;

  localparam int unsigned LenW   = 16;
  localparam int unsigned HashW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;
  localparam logic [LenW-1:0] LenReset = 16'd101;

  typedef enum logic [1:0] {
    TAIL_NONE  = 2'd0,
    TAIL_ONE   = 2'd1,
    TAIL_TWO   = 2'd2,
    TAIL_THREE = 2'd3
  } tail_e;

  typedef struct packed {
    logic             valid;
    logic [HashW-1:0] hash;
    tail_e            tail;
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
    logic [ByteW-1:0] b2;
  } job_t;

  function automatic logic [HashW-1:0] sext8(input logic [ByteW-1:0] b);
    return {{(HashW-ByteW){b[ByteW-1]}}, b};
  endfunction

  function automatic logic [HashW-1:0] group_mix(input logic [HashW-1:0] h,
                                                 input logic [15:0] lo,
                                                 input logic [15:0] hi);
    logic [HashW-1:0] h2;
    logic [HashW-1:0] t;
    logic [HashW-1:0] h3;
    h2 = h + {16'd0, lo};
    t  = ({16'd0, hi} << 11) ^ h2;
    h3 = (h2 << 16) ^ t;
    return h3 + (h3 >> 11);
  endfunction

  function automatic logic [HashW-1:0] tail_mix(input logic [HashW-1:0] h,
                                                input tail_e tail,
                                                input logic [ByteW-1:0] b0,
                                                input logic [ByteW-1:0] b1,
                                                input logic [ByteW-1:0] b2);
    logic [HashW-1:0] r;
    r = h;
    case (tail)
      TAIL_THREE: begin
        r = r + {16'd0, b1, b0};
        r = r ^ (r << 16);
        r = r ^ (sext8(b2) << 18);
        r = r + (r >> 11);
      end
      TAIL_TWO: begin
        r = r + {16'd0, b1, b0};
        r = r ^ (r << 11);
        r = r + (r >> 17);
      end
      TAIL_ONE: begin
        r = r + sext8(b0);
        r = r ^ (r << 10);
        r = r + (r >> 1);
      end
      default: begin
        r = h;
      end
    endcase
    return r;
  endfunction

  function automatic logic [HashW-1:0] aval_a(input logic [HashW-1:0] h);
    logic [HashW-1:0] r;
    r = h ^ (h << 3);
    r = r + (r >> 5);
    return r;
  endfunction

  function automatic logic [HashW-1:0] aval_b(input logic [HashW-1:0] h);
    logic [HashW-1:0] r;
    r = h ^ (h << 4);
    r = r + (r >> 17);
    r = r ^ (r << 25);
    r = r + (r >> 6);
    return r;
  endfunction

endpackage

### rtl/sfh_regs.sv
// APB-style configuration register holding the message length.
module sfh_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfh_pkg::AddrW-1:0]  paddr,
  input  logic [sfh_pkg::DataW-1:0]  pwdata,
  output logic [sfh_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output logic [sfh_pkg::LenW-1:0]   msg_length_o
);

  logic [sfh_pkg::LenW-1:0] len_q;
  logic [sfh_pkg::LenW-1:0] len_d;
  logic                     sel_len;

  assign sel_len = (paddr[sfh_pkg::AddrW-1] == 1'b0);
  assign pready  = 1'b1;

  always_comb begin
    len_d = len_q;
    if (psel && penable && pwrite && sel_len) begin
      len_d = pwdata[sfh_pkg::LenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= sfh_pkg::LenReset;
    end else begin
      len_q <= len_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_len) begin
      prdata = {{(sfh_pkg::DataW-sfh_pkg::LenW){1'b0}}, len_q};
    end
  end

  assign msg_length_o = len_q;

endmodule

### rtl/sfh_mix.sv
// Message state: byte count, group gathering and per-group mixing of the hash.
module sfh_mix (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  logic                        in_valid_i,
  input  logic [sfh_pkg::ByteW-1:0]   data_byte_i,
  input  logic [sfh_pkg::LenW-1:0]    msg_length_i,
  output sfh_pkg::job_t               job_o
);

  logic [sfh_pkg::HashW-1:0] acc_q, acc_d;
  logic [sfh_pkg::LenW-1:0]  seen_q, seen_d;
  logic [sfh_pkg::ByteW-1:0] gb_q [3];
  logic [sfh_pkg::ByteW-1:0] gb_d [3];
  sfh_pkg::job_t             job_q, job_d;

  logic                      take;
  logic [1:0]                lane;
  logic [sfh_pkg::LenW:0]    count;
  logic                      last;
  logic [sfh_pkg::HashW-1:0] base;
  logic [sfh_pkg::HashW-1:0] mixed;

  assign take  = in_valid_i && advance_i && (msg_length_i != '0);
  assign lane  = seen_q[1:0];
  assign count = {1'b0, seen_q} + {{sfh_pkg::LenW{1'b0}}, 1'b1};
  assign last  = (count >= {1'b0, msg_length_i});
  assign base  = (seen_q == '0) ? {{(sfh_pkg::HashW-sfh_pkg::LenW){1'b0}}, msg_length_i}
                                : acc_q;
  assign mixed = sfh_pkg::group_mix(base, {gb_q[1], gb_q[0]}, {data_byte_i, gb_q[2]});

  always_comb begin
    acc_d  = acc_q;
    seen_d = seen_q;
    gb_d   = gb_q;
    job_d  = job_q;
    if (advance_i) begin
      job_d.valid = 1'b0;
    end
    if (take) begin
      if (lane == 2'd3) begin
        acc_d = mixed;
      end else begin
        acc_d          = base;
        gb_d[lane]     = data_byte_i;
      end
      seen_d      = last ? '0 : count[sfh_pkg::LenW-1:0];
      job_d.valid = last;
      job_d.hash  = acc_d;
      job_d.tail  = sfh_pkg::tail_e'(count[1:0]);
      job_d.b0    = gb_d[0];
      job_d.b1    = gb_d[1];
      job_d.b2    = gb_d[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      seen_q <= '0;
      job_q  <= '0;
    end else begin
      acc_q  <= acc_d;
      seen_q <= seen_d;
      job_q  <= job_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gb_q <= gb_d;
  end

  assign job_o = job_q;

endmodule

### rtl/sfh_final.sv
// Tail mixing and avalanche steps, ending in the result register.
module sfh_final (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  sfh_pkg::job_t               job_i,
  output logic                        out_valid_o,
  output logic [sfh_pkg::HashW-1:0]   hash_value_o
);

  logic                      s2_valid_q, s2_valid_d;
  logic [sfh_pkg::HashW-1:0] s2_hash_q, s2_hash_d;
  logic                      res_valid_q, res_valid_d;
  logic [sfh_pkg::HashW-1:0] res_hash_q, res_hash_d;

  always_comb begin
    s2_valid_d  = s2_valid_q;
    s2_hash_d   = s2_hash_q;
    res_valid_d = res_valid_q;
    res_hash_d  = res_hash_q;
    if (advance_i) begin
      s2_valid_d  = job_i.valid;
      s2_hash_d   = sfh_pkg::aval_a(sfh_pkg::tail_mix(job_i.hash, job_i.tail,
                                                      job_i.b0, job_i.b1, job_i.b2));
      res_valid_d = s2_valid_q;
      res_hash_d  = sfh_pkg::aval_b(s2_hash_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_hash_q  <= s2_hash_d;
    res_hash_q <= res_hash_d;
  end

  assign out_valid_o  = res_valid_q;
  assign hash_value_o = res_hash_q;

endmodule

### rtl/superfasthash_byte_stream.sv
// Top level of the SuperFastHash byte stream engine.
// Throughput: one byte per cycle while in_ready_o is high; each byte is folded into the
// message state as it is taken. The finished job moves from the job register through the
// s2 register into the result register, one step per pipeline advance.
// The three stages advance together whenever the result register is empty or being taken.
// Reset clears the byte count, the running hash and all valid flags, and sets the length to 101.
module superfasthash_byte_stream (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfh_pkg::AddrW-1:0]   paddr,
  input  logic [sfh_pkg::DataW-1:0]   pwdata,
  output logic [sfh_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [sfh_pkg::ByteW-1:0]   data_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sfh_pkg::HashW-1:0]   hash_value_o
);

  logic [sfh_pkg::LenW-1:0] msg_length;
  logic                     advance;
  sfh_pkg::job_t            job;

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  sfh_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .msg_length_o (msg_length)
  );

  sfh_mix u_mix (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .in_valid_i   (in_valid_i),
    .data_byte_i  (data_byte_i),
    .msg_length_i (msg_length),
    .job_o        (job)
  );

  sfh_final u_final (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .job_i        (job),
    .out_valid_o  (out_valid_o),
    .hash_value_o (hash_value_o)
  );

endmodule

### rtl/sfh_checker.sv
// Port-level checker for the SuperFastHash byte stream, bound to the top level.
module sfh_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [sfh_pkg::AddrW-1:0]   paddr,
  input logic [sfh_pkg::DataW-1:0]   pwdata,
  input logic [sfh_pkg::DataW-1:0]   prdata,
  input logic                        pready,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [sfh_pkg::HashW-1:0]   hash_value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hash_value_o))
    else $error("Stalled result transaction changed.");

  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("Input ready does not track the result register.");

  a_len_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && !paddr[sfh_pkg::AddrW-1]) ##1
    !paddr[sfh_pkg::AddrW-1] |-> prdata[sfh_pkg::LenW-1:0] == $past(pwdata[sfh_pkg::LenW-1:0]))
    else $error("Length register readback mismatch.");

  a_len_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata[sfh_pkg::DataW-1:sfh_pkg::LenW] == '0)
    else $error("Unused read data bits are not zero.");

endmodule

bind superfasthash_byte_stream sfh_checker u_sfh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata),
  .pready       (pready),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .hash_value_o (hash_value_o)
);
